// File: design/assert_macros.svh
// assertion helpers, shared by every file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge out of reset
`define SWM_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define SWM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int SAMPLE_W       = 32;
    localparam int MEDIAN_W       = 33;
    localparam int WSIZE_W        = 7;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd1;

    // broadcast from the control to every cell of the sorted row
    typedef struct packed {
        logic                       load;
        logic                       full;
        logic signed [SAMPLE_W-1:0] sample;
    } t_cell_ctrl;

endpackage

// File: design/swm_sample_if.sv
`timescale 1ns / 1ps

interface swm_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [swm_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: design/swm_median_if.sv
`timescale 1ns / 1ps

interface swm_median_if;
    logic                                valid;
    logic                                ready;
    logic signed [swm_pkg::MEDIAN_W-1:0] median_doubled;

    modport source (output valid, output median_doubled, input ready);
    modport sink   (input valid, input median_doubled, output ready);
endinterface

// File: design/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
    parameter int INDEX      = 0,
    parameter int IW         = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    parameter int CW         = $clog2(MAX_WINDOW + 1)
) (
    input  logic                                i_clk,
    input  swm_pkg::t_cell_ctrl                 i_ctrl,
    input  logic [IW-1:0]                       i_del_idx,
    input  logic [CW-1:0]                       i_cnt,
    input  logic [CW-1:0]                       i_win,
    input  logic [IW-1:0]                       i_lo_idx,
    input  logic [IW-1:0]                       i_hi_idx,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_left_value,
    input  logic [IW-1:0]                       i_left_age,
    input  logic                                i_left_le,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_right_value,
    input  logic [IW-1:0]                       i_right_age,
    input  logic                                i_right_le,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_value,
    output logic [IW-1:0]                       o_age,
    output logic                                o_le,
    output logic                                o_del,
    output logic [swm_pkg::SAMPLE_W-1:0]        o_lo_tap,
    output logic [swm_pkg::SAMPLE_W-1:0]        o_hi_tap
);

    localparam logic [IW-1:0] K     = IW'(INDEX);
    localparam bit            FIRST = (INDEX == 0);
    localparam int            KL    = (INDEX > 0) ? INDEX - 1 : 0;

    logic signed [swm_pkg::SAMPLE_W-1:0] r_value, n_value;
    logic [IW-1:0]                       r_age, n_age;

    logic [CW-1:0]                       w_keep;
    logic                                w_shift_self, w_shift_left;
    logic signed [swm_pkg::SAMPLE_W-1:0] w_self_value, w_left_value;
    logic [IW-1:0]                       w_self_age, w_left_age;
    logic                                w_self_le, w_left_le;
    logic                                w_below_self, w_below_left;

    assign o_value  = r_value;
    assign o_age    = r_age;
    assign o_le     = (r_value <= i_ctrl.sample);
    assign o_del    = i_ctrl.full && (CW'(INDEX) < i_cnt) && (CW'(r_age) == i_win - CW'(1));
    assign o_lo_tap = (K == i_lo_idx) ? r_value : '0;
    assign o_hi_tap = (K == i_hi_idx) ? r_value : '0;

    // entries kept after the oldest one leaves
    assign w_keep = i_cnt - CW'(i_ctrl.full);

    // entries at or above the leaving one close the gap from the right
    assign w_shift_self = i_ctrl.full && (K >= i_del_idx);
    assign w_shift_left = i_ctrl.full && (K > i_del_idx);

    always_comb begin
        w_self_value = w_shift_self ? i_right_value : r_value;
        w_self_age   = w_shift_self ? i_right_age   : r_age;
        w_self_le    = w_shift_self ? i_right_le    : o_le;
        w_left_value = w_shift_left ? r_value       : i_left_value;
        w_left_age   = w_shift_left ? r_age         : i_left_age;
        w_left_le    = w_shift_left ? o_le          : i_left_le;

        w_below_self = (CW'(INDEX) < w_keep) && w_self_le;
        w_below_left = !FIRST && (CW'(KL) < w_keep) && w_left_le;

        if (w_below_self) begin
            n_value = w_self_value;
            n_age   = IW'(w_self_age + 1'b1);
        end else if (FIRST || w_below_left) begin
            n_value = i_ctrl.sample;
            n_age   = '0;
        end else begin
            n_value = w_left_value;
            n_age   = IW'(w_left_age + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

endmodule

// File: design/sliding_window_median.sv
// result: an accepted sample stays pending while the sorted cell row updates; once the window is
// full and the output register is free, its result is registered there and then waits until taken
// pacing: no new sample is taken while one is pending, so the middle-tap select and add
// that follows each update of the sorted cell row, and a busy output register, hold the flow
// reset: window size returns to one and the window is emptied; cell contents are not reset
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sliding_window_median #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    swm_sample_if.sink                        i_sample,
    swm_median_if.source                      o_median,
    input  logic                              i_cfg_we,
    input  logic [swm_pkg::WSIZE_W-1:0]       i_cfg_wdata
);

    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);

    logic [swm_pkg::WSIZE_W-1:0]          r_wsize;
    logic [CW-1:0]                        r_cnt;
    logic                                 r_pend;
    logic                                 r_out_valid;
    logic signed [swm_pkg::MEDIAN_W-1:0]  r_median;

    logic [CW-1:0]                        w_win;
    logic                                 w_full;
    logic                                 w_accept;
    logic                                 w_out_free;
    logic                                 w_emit;
    swm_pkg::t_cell_ctrl                  w_ctrl;
    logic [IW-1:0]                        w_del_idx;
    logic [IW-1:0]                        w_lo_idx, w_hi_idx;
    logic [swm_pkg::SAMPLE_W-1:0]         w_lo, w_hi;

    logic signed [swm_pkg::SAMPLE_W-1:0]  w_value [MAX_WINDOW];
    logic [IW-1:0]                        w_age   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]                w_le;
    logic [MAX_WINDOW-1:0]                w_del;
    logic [swm_pkg::SAMPLE_W-1:0]         w_lo_tap [MAX_WINDOW];
    logic [swm_pkg::SAMPLE_W-1:0]         w_hi_tap [MAX_WINDOW];

    // zero means one, anything above the row length saturates
    always_comb begin
        if (r_wsize == '0) begin
            w_win = CW'(1);
        end else if (32'(r_wsize) > MAX_WINDOW) begin
            w_win = CW'(MAX_WINDOW);
        end else begin
            w_win = CW'(r_wsize);
        end
    end

    assign w_full     = (r_cnt == w_win);
    assign w_accept   = i_sample.valid && i_sample.ready;
    assign w_out_free = !r_out_valid || o_median.ready;
    assign w_emit     = r_pend && w_full && w_out_free;

    assign i_sample.ready        = !r_pend;
    assign o_median.valid        = r_out_valid;
    assign o_median.median_doubled = r_median;

    assign w_ctrl.load   = w_accept;
    assign w_ctrl.full   = w_full;
    assign w_ctrl.sample = i_sample.sample;

    assign w_lo_idx = IW'((w_win - CW'(1)) >> 1);
    assign w_hi_idx = IW'(w_win >> 1);

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic signed [swm_pkg::SAMPLE_W-1:0] w_lv, w_rv;
        logic [IW-1:0]                       w_la, w_ra;
        logic                                w_ll, w_rl;

        if (g == 0) begin : g_left_edge
            assign w_lv = '0;
            assign w_la = '0;
            assign w_ll = 1'b0;
        end else begin : g_left
            assign w_lv = w_value[g-1];
            assign w_la = w_age[g-1];
            assign w_ll = w_le[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_right_edge
            assign w_rv = '0;
            assign w_ra = '0;
            assign w_rl = 1'b0;
        end else begin : g_right
            assign w_rv = w_value[g+1];
            assign w_ra = w_age[g+1];
            assign w_rl = w_le[g+1];
        end

        swm_cell #(
            .MAX_WINDOW (MAX_WINDOW),
            .INDEX      (g),
            .IW         (IW),
            .CW         (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_del_idx     (w_del_idx),
            .i_cnt         (r_cnt),
            .i_win         (w_win),
            .i_lo_idx      (w_lo_idx),
            .i_hi_idx      (w_hi_idx),
            .i_left_value  (w_lv),
            .i_left_age    (w_la),
            .i_left_le     (w_ll),
            .i_right_value (w_rv),
            .i_right_age   (w_ra),
            .i_right_le    (w_rl),
            .o_value       (w_value[g]),
            .o_age         (w_age[g]),
            .o_le          (w_le[g]),
            .o_del         (w_del[g]),
            .o_lo_tap      (w_lo_tap[g]),
            .o_hi_tap      (w_hi_tap[g])
        );
    end

    // one-hot leaving flag to index, and the two middle taps
    always_comb begin
        w_del_idx = '0;
        w_lo      = '0;
        w_hi      = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (w_del[i]) begin
                w_del_idx = w_del_idx | IW'(i);
            end
            w_lo = w_lo | w_lo_tap[i];
            w_hi = w_hi | w_hi_tap[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize     <= swm_pkg::WSIZE_RESET;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wsize <= i_cfg_wdata;
                r_cnt   <= '0;
            end else if (w_accept && !w_full) begin
                r_cnt <= r_cnt + CW'(1);
            end

            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (r_pend && (!w_full || w_out_free)) begin
                r_pend <= 1'b0;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_median.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_median <= swm_pkg::MEDIAN_W'($signed(w_lo)) + swm_pkg::MEDIAN_W'($signed(w_hi));
        end
    end

    `SWM_ASSERT_ALWAYS(a_cnt_in_window, i_clk, i_rst_n, r_cnt <= w_win)
    `SWM_ASSERT_SAME(a_one_leaving, i_clk, i_rst_n, w_accept && w_full, $onehot(w_del))
    `SWM_ASSERT_NEXT(a_accept_pends, i_clk, i_rst_n, w_accept && !i_cfg_we, r_pend)
    `SWM_ASSERT_NEXT(a_no_result_drops, i_clk, i_rst_n, r_pend && !w_full && !w_accept, !r_pend)

endmodule
